@@ rtl/next_permutation_engine_defines.svh @@
// assertion macros shared by the next permutation engine rtl
`ifndef NEXT_PERMUTATION_ENGINE_DEFINES_SVH
`define NEXT_PERMUTATION_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NPE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/npe_pkg.sv @@
// types, codes and helpers of the next permutation engine
`timescale 1ns / 1ps

package npe_pkg;

  localparam int unsigned ModeBits   = 2;
  localparam int unsigned IndexBits  = 4;
  localparam int unsigned ValueBits  = 16;
  localparam int unsigned LengthBits = 5;

  localparam logic [ModeBits-1:0] MODE_WRITE   = 2'd0;
  localparam logic [ModeBits-1:0] MODE_ADVANCE = 2'd1;
  localparam logic [ModeBits-1:0] MODE_READ    = 2'd2;

  localparam logic [LengthBits-1:0] ACTIVE_LENGTH_RESET = 5'd16;

  typedef struct packed {
    logic [ModeBits-1:0]  mode;
    logic [IndexBits-1:0] index;
    logic [ValueBits-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [ValueBits-1:0] read_value;
    logic                 advanced;
  } out_item_t;

  typedef logic [4:0] step_t;

  // microprogram addresses
  localparam step_t ST_START    = 5'd0;
  localparam step_t ST_RD_CUR   = 5'd1;
  localparam step_t ST_LD_CUR   = 5'd2;
  localparam step_t ST_LOOP     = 5'd3;
  localparam step_t ST_SCAN     = 5'd4;
  localparam step_t ST_SUCC_RD  = 5'd5;
  localparam step_t ST_SUCC_CMP = 5'd6;
  localparam step_t ST_SWAP_A   = 5'd7;
  localparam step_t ST_SWAP_B   = 5'd8;
  localparam step_t ST_REV      = 5'd9;
  localparam step_t ST_REV_LO   = 5'd10;
  localparam step_t ST_REV_HI   = 5'd11;
  localparam step_t ST_REV_WB   = 5'd12;
  localparam step_t ST_FIN0     = 5'd13;
  localparam step_t ST_FIN1     = 5'd14;
  localparam step_t ST_WR       = 5'd15;
  localparam step_t ST_RD       = 5'd16;
  localparam step_t ST_RD_FIN   = 5'd17;

  typedef enum logic [1:0] {
    ADDR_P,
    ADDR_PM1,
    ADDR_S,
    ADDR_IDX
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_VA,
    WD_VB,
    WD_RDATA,
    WD_WVAL
  } wdata_sel_e;

  typedef enum logic [1:0] {
    P_HOLD,
    P_LOAD_N1,
    P_DEC,
    P_INC
  } p_op_e;

  typedef enum logic [1:0] {
    S_HOLD,
    S_LOAD_N1,
    S_DEC
  } s_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_LEN_SHORT,
    C_P_ZERO,
    C_RD_GE_VA,
    C_VA_GE_RD,
    C_P_GE_S
  } cond_e;

  typedef enum logic [0:0] {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    addr_sel_e  raddr_sel;
    logic       wr_en;
    addr_sel_e  waddr_sel;
    wdata_sel_e wdata_sel;
    logic       ld_va;
    logic       ld_vb;
    p_op_e      p_op;
    s_op_e      s_op;
    logic       gate_ptr;
    cond_e      cond;
    step_t      target;
    logic       done;
    logic       adv;
    logic       rv_mem;
  } cw_t;

  localparam cw_t CW_NOP = '0;

  typedef struct packed {
    cw_t  cw;
    logic run;
    logic take;
    logic accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic len_short;
    logic p_zero;
    logic rd_ge_va;
    logic va_ge_rd;
    logic p_ge_s;
  } status_t;

  function automatic step_t entry_step(logic [ModeBits-1:0] mode);
    step_t s;
    unique case (mode)
      MODE_WRITE:   s = ST_WR;
      MODE_ADVANCE: s = ST_START;
      MODE_READ:    s = ST_RD;
      default:      s = ST_FIN0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/npe_stream_if.sv @@
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface npe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/npe_ucode_rom.sv @@
// control store: one control word per microprogram step
`timescale 1ns / 1ps

module npe_ucode_rom import npe_pkg::*; (
  input  step_t step_i,
  output cw_t   cw_o
);

  always_comb begin
    cw_o = CW_NOP;
    unique case (step_i)
      ST_START: begin
        cw_o.p_op   = P_LOAD_N1;
        cw_o.s_op   = S_LOAD_N1;
        cw_o.cond   = C_LEN_SHORT;
        cw_o.target = ST_FIN0;
      end
      ST_RD_CUR: begin
        cw_o.raddr_sel = ADDR_P;
      end
      ST_LD_CUR: begin
        cw_o.ld_va = 1'b1;
      end
      ST_LOOP: begin
        cw_o.raddr_sel = ADDR_PM1;
        cw_o.cond      = C_P_ZERO;
        cw_o.target    = ST_FIN0;
      end
      // va takes the left neighbor either way: new reference or pivot value
      ST_SCAN: begin
        cw_o.ld_va  = 1'b1;
        cw_o.p_op   = P_DEC;
        cw_o.cond   = C_RD_GE_VA;
        cw_o.target = ST_LOOP;
      end
      ST_SUCC_RD: begin
        cw_o.raddr_sel = ADDR_S;
      end
      ST_SUCC_CMP: begin
        cw_o.ld_vb    = 1'b1;
        cw_o.s_op     = S_DEC;
        cw_o.gate_ptr = 1'b1;
        cw_o.cond     = C_VA_GE_RD;
        cw_o.target   = ST_SUCC_RD;
      end
      ST_SWAP_A: begin
        cw_o.wr_en     = 1'b1;
        cw_o.waddr_sel = ADDR_P;
        cw_o.wdata_sel = WD_VB;
      end
      ST_SWAP_B: begin
        cw_o.wr_en     = 1'b1;
        cw_o.waddr_sel = ADDR_S;
        cw_o.wdata_sel = WD_VA;
        cw_o.p_op      = P_INC;
        cw_o.s_op      = S_LOAD_N1;
      end
      ST_REV: begin
        cw_o.raddr_sel = ADDR_P;
        cw_o.cond      = C_P_GE_S;
        cw_o.target    = ST_FIN1;
      end
      ST_REV_LO: begin
        cw_o.ld_va     = 1'b1;
        cw_o.raddr_sel = ADDR_S;
      end
      ST_REV_HI: begin
        cw_o.wr_en     = 1'b1;
        cw_o.waddr_sel = ADDR_P;
        cw_o.wdata_sel = WD_RDATA;
      end
      ST_REV_WB: begin
        cw_o.wr_en     = 1'b1;
        cw_o.waddr_sel = ADDR_S;
        cw_o.wdata_sel = WD_VA;
        cw_o.p_op      = P_INC;
        cw_o.s_op      = S_DEC;
        cw_o.cond      = C_ALWAYS;
        cw_o.target    = ST_REV;
      end
      ST_FIN0: begin
        cw_o.done = 1'b1;
      end
      ST_FIN1: begin
        cw_o.done = 1'b1;
        cw_o.adv  = 1'b1;
      end
      ST_WR: begin
        cw_o.wr_en     = 1'b1;
        cw_o.waddr_sel = ADDR_IDX;
        cw_o.wdata_sel = WD_WVAL;
        cw_o.done      = 1'b1;
      end
      ST_RD: begin
        cw_o.raddr_sel = ADDR_IDX;
      end
      ST_RD_FIN: begin
        cw_o.raddr_sel = ADDR_IDX;
        cw_o.done      = 1'b1;
        cw_o.rv_mem    = 1'b1;
      end
      default: begin
        cw_o.done = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/npe_sequencer.sv @@
// step counter, branch logic and transaction dispatch of the microprogram
`timescale 1ns / 1ps
`include "next_permutation_engine_defines.svh"

module npe_sequencer import npe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [ModeBits-1:0] mode_i,
  input  status_t             status_i,
  input  logic                out_free_i,
  output logic                in_ready_o,
  output dp_ctrl_t            ctrl_o,
  output logic                fire_o
);

  seq_state_e state_q, state_d;
  step_t      step_q, step_d;
  cw_t        cw;
  logic       take;
  logic       run;

  npe_ucode_rom u_rom (
    .step_i (step_q),
    .cw_o   (cw)
  );

  always_comb begin
    unique case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_LEN_SHORT: take = status_i.len_short;
      C_P_ZERO:    take = status_i.p_zero;
      C_RD_GE_VA:  take = status_i.rd_ge_va;
      C_VA_GE_RD:  take = status_i.va_ge_rd;
      C_P_GE_S:    take = status_i.p_ge_s;
      default:     take = 1'b0;
    endcase
  end

  assign run        = (state_q == SEQ_RUN);
  assign in_ready_o = (state_q == SEQ_IDLE);
  assign fire_o     = run && cw.done && out_free_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = SEQ_RUN;
          step_d  = entry_step(mode_i);
        end
      end
      SEQ_RUN: begin
        if (cw.done) begin
          // hold the finishing step until the result register frees up
          if (out_free_i) begin
            state_d = SEQ_IDLE;
          end
        end else if (take) begin
          step_d = cw.target;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= ST_FIN0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign ctrl_o.cw     = cw;
  assign ctrl_o.run    = run;
  assign ctrl_o.take   = take;
  assign ctrl_o.accept = in_ready_o && in_valid_i;

  `NPE_ASSERT_NXT(a_stall_hold, run && cw.done && !out_free_i, (state_q == SEQ_RUN) && (step_q == $past(step_q)), "finishing step left while result register busy")

endmodule

@@ rtl/npe_datapath.sv @@
// element memory, pointers, value registers and flags of the engine
`timescale 1ns / 1ps
`include "next_permutation_engine_defines.svh"

module npe_datapath import npe_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 16,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_ctrl_t              ctrl_i,
  input  in_item_t              item_i,
  input  logic [LengthBits-1:0] active_length_i,
  output status_t               status_o,
  output logic [ValueBits-1:0]  read_value_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW = $clog2(MAX_ELEMENTS + 1);

  logic [ELEMENT_BITS-1:0] mem_q [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] rdata_q;
  logic [ELEMENT_BITS-1:0] va_q;
  logic [ELEMENT_BITS-1:0] vb_q;
  logic [ELEMENT_BITS-1:0] wdata;
  logic [AW-1:0]           p_q, p_d;
  logic [AW-1:0]           s_q, s_d;
  logic [AW-1:0]           raddr, waddr, idx_addr, n_m1;
  logic [LW-1:0]           n;
  logic [IndexBits-1:0]    idx_q;
  logic [ValueBits-1:0]    wval_q;
  logic                    in_range_q;
  logic                    ptr_en;
  logic                    wr_go;

  function automatic logic [AW-1:0] sel_addr(addr_sel_e sel, logic [AW-1:0] p,
                                             logic [AW-1:0] s, logic [AW-1:0] ix);
    logic [AW-1:0] a;
    unique case (sel)
      ADDR_P:   a = p;
      ADDR_PM1: a = p - AW'(1);
      ADDR_S:   a = s;
      ADDR_IDX: a = ix;
      default:  a = p;
    endcase
    return a;
  endfunction

  // lengths above the store size count as the whole store
  always_comb begin
    if (32'(active_length_i) > MAX_ELEMENTS) begin
      n = LW'(MAX_ELEMENTS);
    end else begin
      n = LW'(active_length_i);
    end
  end

  assign n_m1     = AW'(n - LW'(1));
  assign idx_addr = AW'(idx_q);
  assign raddr    = sel_addr(ctrl_i.cw.raddr_sel, p_q, s_q, idx_addr);
  assign waddr    = sel_addr(ctrl_i.cw.waddr_sel, p_q, s_q, idx_addr);

  always_comb begin
    unique case (ctrl_i.cw.wdata_sel)
      WD_VA:    wdata = va_q;
      WD_VB:    wdata = vb_q;
      WD_RDATA: wdata = rdata_q;
      WD_WVAL:  wdata = ELEMENT_BITS'(wval_q);
      default:  wdata = va_q;
    endcase
  end

  // host writes past the store are dropped
  assign wr_go = ctrl_i.run && ctrl_i.cw.wr_en &&
                 ((ctrl_i.cw.waddr_sel != ADDR_IDX) || in_range_q);

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      idx_q      <= item_i.index;
      wval_q     <= item_i.write_value;
      in_range_q <= (32'(item_i.index) < MAX_ELEMENTS);
    end
    if (ctrl_i.run && ctrl_i.cw.ld_va) begin
      va_q <= rdata_q;
    end
    if (ctrl_i.run && ctrl_i.cw.ld_vb) begin
      vb_q <= rdata_q;
    end
  end

  assign ptr_en = ctrl_i.run && (!ctrl_i.cw.gate_ptr || ctrl_i.take);

  always_comb begin
    p_d = p_q;
    s_d = s_q;
    if (ptr_en) begin
      unique case (ctrl_i.cw.p_op)
        P_HOLD:    p_d = p_q;
        P_LOAD_N1: p_d = n_m1;
        P_DEC:     p_d = p_q - AW'(1);
        P_INC:     p_d = p_q + AW'(1);
        default:   p_d = p_q;
      endcase
      unique case (ctrl_i.cw.s_op)
        S_HOLD:    s_d = s_q;
        S_LOAD_N1: s_d = n_m1;
        S_DEC:     s_d = s_q - AW'(1);
        default:   s_d = s_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      s_q <= '0;
    end else begin
      p_q <= p_d;
      s_q <= s_d;
    end
  end

  assign status_o.len_short = (n < LW'(2));
  assign status_o.p_zero    = (p_q == '0);
  assign status_o.rd_ge_va  = (rdata_q >= va_q);
  assign status_o.va_ge_rd  = (va_q >= rdata_q);
  assign status_o.p_ge_s    = (p_q >= s_q);

  assign read_value_o = in_range_q ? ValueBits'(rdata_q) : '0;

  `NPE_ASSERT_IMP(a_perm_wr_in_len, ctrl_i.run && ctrl_i.cw.wr_en && (ctrl_i.cw.waddr_sel != ADDR_IDX), 32'(waddr) < 32'(n), "permutation write outside active length")

endmodule

@@ rtl/next_permutation_engine.sv @@
// top level of the next permutation engine
`timescale 1ns / 1ps
`include "next_permutation_engine_defines.svh"

// Steps an array of up to MAX_ELEMENTS unsigned elements to its next
// permutation in lexicographic order; repeated values give each distinct
// arrangement once. A transaction on in_i writes one element (mode 0),
// advances (mode 1) or reads one element (mode 2); each gives exactly one
// transaction on out_o. An advance scans the descending tail for the pivot,
// scans for the successor, swaps the two and then reverses the suffix by
// swaps. The microprogram touches the element memory through one read and
// one write port, one element per step. One transaction is in work at a
// time; in_i is ready again once its result is in the output register.
// Elements never written read back as undefined. The user must write
// active_length through cfg_we_i/cfg_wdata_i only while no transaction is
// in work; the block itself does not enforce this.
module next_permutation_engine import npe_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 16,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LengthBits-1:0] cfg_wdata_i,
  npe_stream_if.sink            in_i,
  npe_stream_if.source          out_o
);

  logic [LengthBits-1:0] active_length_q;
  dp_ctrl_t              ctrl;
  status_t               status;
  logic [ValueBits-1:0]  mem_value;
  logic                  fire;
  logic                  out_free;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_length_q <= ACTIVE_LENGTH_RESET;
    end else if (cfg_we_i) begin
      active_length_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  npe_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .mode_i     (in_i.payload.mode),
    .status_i   (status),
    .out_free_i (out_free),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl),
    .fire_o     (fire)
  );

  npe_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .item_i          (in_i.payload),
    .active_length_i (active_length_q),
    .status_o        (status),
    .read_value_o    (mem_value)
  );

  // output register parts the result from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q.read_value <= ctrl.cw.rv_mem ? mem_value : '0;
      out_data_q.advanced   <= ctrl.cw.adv;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  `NPE_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "input accepted twice in a row")
  `NPE_ASSERT_IMP(a_adv_no_data, out_valid_q && out_data_q.advanced, out_data_q.read_value == '0, "advance result carries read data")

endmodule

@@ tb/sv/npe_tb_pkg.sv @@
// scoreboard class that predicts and checks next permutation engine results
`timescale 1ns / 1ps

package npe_tb_pkg;
  import npe_pkg::*;

  localparam int unsigned NumElements = 16;
  localparam logic [ModeBits-1:0] MODE_UNUSED = 2'd3;

  class npe_scoreboard;
    logic [ValueBits-1:0] elem [NumElements];
    int unsigned active_len;
    out_item_t awaited_outputs [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned perms_formed;
    int unsigned perms_at_last;
    bit at_last;

    function new();
      foreach (elem[i]) elem[i] = '0;
      active_len = 32'(ACTIVE_LENGTH_RESET);
      errors = 0;
      checked = 0;
      perms_formed = 0;
      perms_at_last = 0;
      at_last = 1'b0;
    endfunction

    function void set_length(logic [LengthBits-1:0] len);
      active_len = 32'(len);
    endfunction

    function int unsigned pending();
      return awaited_outputs.size();
    endfunction

    // steps the active elements to the next arrangement, 0 if already last
    function bit step_to_next_perm();
      int n;
      int piv;
      int succ;
      int lo;
      int hi;
      logic [ValueBits-1:0] t;
      n = (active_len > NumElements) ? NumElements : active_len;
      if (n < 2) return 1'b0;
      piv = n - 1;
      while (piv > 0 && elem[piv-1] >= elem[piv]) piv--;
      if (piv == 0) return 1'b0;
      succ = n - 1;
      while (succ > piv && elem[piv-1] >= elem[succ]) succ--;
      t = elem[piv-1];
      elem[piv-1] = elem[succ];
      elem[succ] = t;
      lo = piv;
      hi = n - 1;
      while (lo < hi) begin
        t = elem[lo];
        elem[lo] = elem[hi];
        elem[hi] = t;
        lo++;
        hi--;
      end
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      e = '0;
      case (it.mode)
        MODE_WRITE: begin
          elem[it.index] = it.write_value;
        end
        MODE_ADVANCE: begin
          e.advanced = step_to_next_perm();
          at_last = !e.advanced;
          if (e.advanced) perms_formed++;
          else perms_at_last++;
        end
        MODE_READ: begin
          e.read_value = elem[it.index];
        end
        default: ;
      endcase
      awaited_outputs = {awaited_outputs, e};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      checked++;
      if (awaited_outputs.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected result: expected none, got read_value %h advanced %b",
                   $time, got.read_value, got.advanced);
        return;
      end
      exp_item = awaited_outputs.pop_front();
      if (got.read_value !== exp_item.read_value) begin
        errors++;
        if (errors <= 40)
          $display("%0t read_value mismatch: expected %h, got %h",
                   $time, exp_item.read_value, got.read_value);
      end
      if (got.advanced !== exp_item.advanced) begin
        errors++;
        if (errors <= 40)
          $display("%0t advanced mismatch: expected %b, got %b",
                   $time, exp_item.advanced, got.advanced);
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_next_permutation_engine.sv @@
// top of the next permutation engine testbench: stimulus, handshakes, end of run
`timescale 1ns / 1ps

module tb_next_permutation_engine;
  import npe_pkg::*;
  import npe_tb_pkg::*;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned CycleLimit = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [LengthBits-1:0] cfg_wdata_i;

  npe_stream_if #(.T(in_item_t)) in_if ();
  npe_stream_if #(.T(out_item_t)) out_if ();

  next_permutation_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  npe_scoreboard sb;
  bit quiet;
  int unsigned items_sent;
  int unsigned length_writes;
  int unsigned cycle_count;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t mk(logic [ModeBits-1:0] m, logic [IndexBits-1:0] idx,
                                  logic [ValueBits-1:0] val);
    in_item_t it;
    it.mode = m;
    it.index = idx;
    it.write_value = val;
    return it;
  endfunction

  task automatic send(in_item_t it);
    int unsigned g;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    if (it.mode != MODE_UNUSED) items_sent++;
    g = pick_gap();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active_length(logic [LengthBits-1:0] len);
    drain();
    cfg_wdata_i <= len;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(len);
    length_writes++;
  endtask

  task automatic load_elements(int unsigned n, bit small_vals);
    for (int unsigned i = 0; i < n; i++)
      send(mk(MODE_WRITE, IndexBits'(i),
              ValueBits'(small_vals ? $urandom_range(0, 3) : $urandom)));
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 1;
    if (r < 15) return 16;
    if (r < 20) return $urandom_range(17, 31);
    if (r < 30) return $urandom_range(7, 15);
    return $urandom_range(2, 6);
  endfunction

  // result side: random stalls on ready
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned len;
    int unsigned n_eff;
    int unsigned budget;
    int unsigned r;
    sb = new();
    quiet = 1'b0;
    items_sent = 0;
    length_writes = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: value and index extremes at the reset length
    for (int unsigned i = 0; i < NumElements; i++)
      send(mk(MODE_WRITE, IndexBits'(i),
              ValueBits'((i == 0) ? 16'h0000 : (i == NumElements - 1) ? 16'hFFFF :
                         (((i % 2) != 0) ? 16'hAAAA : 16'h5555) ^ i)));
    send(mk(MODE_READ, 4'h0, 16'hFFFF));
    send(mk(MODE_READ, 4'hF, 16'h0000));
    send(mk(MODE_ADVANCE, 4'h0, 16'h0000));
    send(mk(MODE_READ, 4'hF, 16'h0000));
    send(mk(MODE_UNUSED, 4'hF, 16'hFFFF));
    // lengths zero and one never advance, too large clamps to the store size
    set_active_length(5'd0);
    send(mk(MODE_ADVANCE, 4'h0, 16'h0000));
    set_active_length(5'd1);
    send(mk(MODE_ADVANCE, 4'h0, 16'h0000));
    set_active_length(5'd31);
    send(mk(MODE_ADVANCE, 4'h0, 16'h0000));
    // non-increasing with a repeat is already the last arrangement
    set_active_length(5'd3);
    send(mk(MODE_WRITE, 4'h0, 16'd2));
    send(mk(MODE_WRITE, 4'h1, 16'd2));
    send(mk(MODE_WRITE, 4'h2, 16'd1));
    send(mk(MODE_ADVANCE, 4'h0, 16'h0000));

    target = items_sent + RandomItems;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 4) == 0);
      len = pick_length();
      set_active_length(LengthBits'(len));
      n_eff = (len > NumElements) ? NumElements : len;
      load_elements(n_eff, $urandom_range(0, 1) != 0);
      budget = $urandom_range(30, 120);
      repeat (budget) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          send(mk(MODE_WRITE, IndexBits'($urandom_range(0, 15)), ValueBits'($urandom)));
        else if (r < 9)
          send(mk(MODE_UNUSED, IndexBits'($urandom), ValueBits'($urandom)));
        else if (r < 20)
          send(mk(MODE_READ, IndexBits'($urandom_range(0, 15)), ValueBits'($urandom)));
        else if (sb.at_last && r < 60)
          load_elements(n_eff, $urandom_range(0, 1) != 0);
        else
          send(mk(MODE_ADVANCE, IndexBits'($urandom), ValueBits'($urandom)));
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d transactions over %0d length settings, lengths 0 to 31",
             sb.checked, length_writes);
    $display("advances: %0d formed a new arrangement, %0d found the last one",
             sb.perms_formed, sb.perms_at_last);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ next_permutation_engine.f @@
+incdir+rtl
rtl/npe_pkg.sv
rtl/npe_stream_if.sv
rtl/npe_ucode_rom.sv
rtl/npe_sequencer.sv
rtl/npe_datapath.sv
rtl/next_permutation_engine.sv
tb/sv/npe_tb_pkg.sv
tb/sv/tb_next_permutation_engine.sv
